// ----- rtl/scd_pkg.sv -----
`timescale 1ns / 1ps

package scd_pkg;

  // Directory geometry
  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned OPCODE_W = 2;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // Opcodes as they arrive on the input port
  localparam logic [OPCODE_W-1:0] OPC_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OPC_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OPC_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SECTOR_W-1:0] sector;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

// ----- rtl/sector_cache_directory.sv -----
`timescale 1ns / 1ps
// A read or write hit, or a miss with room, goes through the command queue, the pop with tag compare
// and the decide state before its item is registered on the output; no new command is popped until
// decide is done. Flush or full-store miss: scan slots up to the last dirty one, one writeback item per
// dirty slot, or one closing item if none is dirty. A 2-deep command queue keeps accepting until full.
// Reset (async, active low) empties the queue, clears entry count, dirty bits and output valid;
// tags stay undefined and need no clearing pass, as no slot beyond the count is ever compared.

module sector_cache_directory import scd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [SECTOR_W-1:0] sector_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                wb_valid_o,
  output logic [SECTOR_W-1:0] wb_sector_o,
  output logic [SLOT_W-1:0]   wb_slot_o,
  output logic                hit_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic                last_o
);

  qhead_t head;
  logic   pop;

  // Front end: decode the opcode, drop unused codes, queue the command
  scd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sector_i   (sector_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Back end: tag compare, allocation, dirty tracking and writeback drain
  scd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .wb_valid_o  (wb_valid_o),
    .wb_sector_o (wb_sector_o),
    .wb_slot_o   (wb_slot_o),
    .hit_o       (hit_o),
    .slot_o      (slot_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/scd_front.sv -----
`timescale 1ns / 1ps

module scd_front import scd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [SECTOR_W-1:0] sector_i,
  input  logic                pop_i,
  output qhead_t              head_o
);

  logic              keep;
  op_e               dec_op;
  logic              push;
  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0] fill_q, fill_d;

  // Classify the opcode; drop the unused code at the door
  always_comb begin
    keep   = 1'b1;
    dec_op = OP_READ;
    unique case (opcode_i)
      OPC_READ:  dec_op = OP_READ;
      OPC_WRITE: dec_op = OP_WRITE;
      OPC_FLUSH: dec_op = OP_FLUSH;
      default:   keep   = 1'b0;
    endcase
  end

  assign in_ready_o = (fill_q != QFILL_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o && keep;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + QFILL_W'(push) - QFILL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{op: dec_op, sector: sector_i};
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = q_mem[rd_ptr_q];

endmodule

// ----- rtl/scd_back.sv -----
`timescale 1ns / 1ps

module scd_back import scd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qhead_t              head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                wb_valid_o,
  output logic [SECTOR_W-1:0] wb_sector_o,
  output logic [SLOT_W-1:0]   wb_slot_o,
  output logic                hit_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic                last_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]          state_q, state_d;
  op_e                 op_q, op_d;
  logic [SECTOR_W-1:0] sec_q, sec_d;
  logic [ENTRIES-1:0]  match_q, match_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ENTRIES-1:0]  dirty_q, dirty_d;
  logic [SECTOR_W-1:0] tag_q [ENTRIES];
  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] tag_rd_q;

  logic [ENTRIES-1:0]  valid_mask;
  logic                hit;
  logic [IDX_W-1:0]    hit_slot;
  logic                out_free;
  logic                is_flush;
  logic                full;
  logic [ENTRIES-1:0]  idx_oh;
  logic                only_dirty;
  logic                alloc_en;
  logic [IDX_W-1:0]    alloc_slot;
  logic                alloc_dirty;

  logic                emit;
  logic                e_wb;
  logic [SECTOR_W-1:0] e_sec;
  logic [SLOT_W-1:0]   e_wbslot;
  logic                e_hit;
  logic [SLOT_W-1:0]   e_slot;
  logic                e_last;

  logic                out_valid_q;
  logic                wb_valid_q;
  logic [SECTOR_W-1:0] wb_sector_q;
  logic [SLOT_W-1:0]   wb_slot_q;
  logic                hit_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                last_q;

  // Parallel tag compare against the queue head, one comparator per slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_mask[i] = (CNT_W'(i) < count_q);
      match_d[i]    = valid_mask[i] && (tag_q[i] == head_i.cmd.sector);
    end
  end

  // Valid tags are unique, so the match vector is one-hot or empty
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
    end
  end

  assign hit         = |match_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign is_flush    = (op_q == OP_FLUSH);
  assign full        = (count_q == CNT_W'(ENTRIES));
  assign idx_oh      = {{(ENTRIES-1){1'b0}}, 1'b1} << idx_q;
  assign only_dirty  = ((dirty_q & ~idx_oh) == '0);
  assign alloc_dirty = (op_q == OP_WRITE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    sec_d      = sec_q;
    idx_d      = idx_q;
    count_d    = count_q;
    dirty_d    = dirty_q;
    pop_o      = 1'b0;
    alloc_en   = 1'b0;
    alloc_slot = count_q[IDX_W-1:0];
    emit       = 1'b0;
    e_wb       = 1'b0;
    e_sec      = '0;
    e_wbslot   = '0;
    e_hit      = 1'b0;
    e_slot     = '0;
    e_last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          op_d    = head_i.cmd.op;
          sec_d   = head_i.cmd.sector;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          if (is_flush || (!hit && full)) begin
            if (dirty_q == '0) begin
              // Nothing to write back: one closing item, then empty the store (a miss keeps its sector in slot 0)
              emit    = 1'b1;
              e_last  = 1'b1;
              count_d = is_flush ? '0 : CNT_W'(1);
              if (!is_flush) begin
                alloc_en   = 1'b1;
                alloc_slot = '0;
                dirty_d[0] = alloc_dirty;
              end
              state_d = S_IDLE;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
          end else if (hit) begin
            emit   = 1'b1;
            e_hit  = 1'b1;
            e_slot = SLOT_W'(hit_slot);
            e_last = 1'b1;
            if (alloc_dirty) begin
              dirty_d[hit_slot] = 1'b1;
            end
            state_d = S_IDLE;
          end else begin
            alloc_en            = 1'b1;
            dirty_d[alloc_slot] = alloc_dirty;
            count_d             = count_q + 1'b1;
            emit                = 1'b1;
            e_slot              = SLOT_W'(alloc_slot);
            e_last              = 1'b1;
            state_d             = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        // Skip clean slots; the tag read for idx_q lands next cycle
        if (dirty_q[idx_q]) begin
          state_d = S_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit           = 1'b1;
          e_wb           = 1'b1;
          e_sec          = tag_rd_q;
          e_wbslot       = SLOT_W'(idx_q);
          e_last         = only_dirty;
          dirty_d[idx_q] = 1'b0;
          if (only_dirty) begin
            count_d = is_flush ? '0 : CNT_W'(1);
            if (!is_flush) begin
              alloc_en   = 1'b1;
              alloc_slot = '0;
              dirty_d[0] = alloc_dirty;
            end
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dirty_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dirty_q     <= dirty_d;
      idx_q       <= idx_d;
      out_valid_q <= emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    sec_q <= sec_d;
    if (pop_o) begin
      match_q <= match_d;
    end
    if (emit) begin
      wb_valid_q  <= e_wb;
      wb_sector_q <= e_sec;
      wb_slot_q   <= e_wbslot;
      hit_q       <= e_hit;
      slot_q      <= e_slot;
      last_q      <= e_last;
    end
  end

  // Tag registers feed the comparators; the memory copy serves writeback reads
  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      tag_q[alloc_slot] <= sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_en) begin
      tag_mem[alloc_slot] <= sec_q;
    end
    tag_rd_q <= tag_mem[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign wb_valid_o  = wb_valid_q;
  assign wb_sector_o = wb_sector_q;
  assign wb_slot_o   = wb_slot_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/scd_checker.sv -----
`timescale 1ns / 1ps

module scd_checker import scd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [OPCODE_W-1:0] opcode_i,
  input logic [SECTOR_W-1:0] sector_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                wb_valid_o,
  input logic [SECTOR_W-1:0] wb_sector_o,
  input logic [SLOT_W-1:0]   wb_slot_o,
  input logic                hit_o,
  input logic [SLOT_W-1:0]   slot_o,
  input logic                last_o
);

  // Hold a stalled item unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(wb_valid_o) &&
      $stable(wb_sector_o) && $stable(wb_slot_o) && $stable(hit_o) &&
      $stable(slot_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // Only writebacks may precede the final item of a command
  a_nonlast_is_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> wb_valid_o)
    else $error("non-final item without writeback");

  // A hit is a single, final item with no writeback
  a_hit_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> last_o && !wb_valid_o)
    else $error("hit item carries writeback or is not final");

  // Writeback fields read zero when no writeback is requested
  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wb_valid_o |-> (wb_sector_o == '0) && (wb_slot_o == '0))
    else $error("writeback fields set without writeback");

endmodule

bind sector_cache_directory scd_checker u_scd_checker (.*);
